>>> rtl/core/ppfi_pkg.sv
// Shared types and constants for the particle pair force integrator.
// No dependencies; ppfi_ifs and the force integrator core import this package.
package ppfi_pkg;

  localparam int TYPES     = 16;
  localparam int TBL_DEPTH = TYPES * TYPES;
  localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  localparam int POS_W  = 40;
  localparam int KIND_W = 4;
  localparam int GAIN_W = 25;
  localparam int CFG_W  = 32;

  localparam logic signed [39:0] VMAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] VMIN = 40'sh80_0000_0000;

  typedef enum logic [2:0] {
    CFG_REPEL_GAIN   = 3'd0,
    CFG_NEAR_RADIUS  = 3'd1,
    CFG_QUIET_BAND   = 3'd2,
    CFG_DAMPING      = 3'd3,
    CFG_TIME_STEP    = 3'd4,
    CFG_CELL_SIZE    = 3'd5,
    CFG_CELLS_ACROSS = 3'd6,
    CFG_CELLS_DOWN   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain;
    logic [31:0]              reach;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/core/ppfi_ifs.sv
// Handshake channels of the force integrator: pair items in, results out,
// configuration writes. Depends on ppfi_pkg.
interface ppfi_pair_if;
  import ppfi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [POS_W-1:0] self_x;
  logic signed [POS_W-1:0] self_y;
  logic signed [POS_W-1:0] self_vx;
  logic signed [POS_W-1:0] self_vy;
  logic [KIND_W-1:0]       self_kind;
  logic signed [POS_W-1:0] peer_x;
  logic signed [POS_W-1:0] peer_y;
  logic [KIND_W-1:0]       peer_kind;
  logic                    final_pair;
  logic signed [GAIN_W-1:0] entry_gain;
  logic [31:0]             entry_reach;
  modport source (output valid, op, self_x, self_y, self_vx, self_vy, self_kind, peer_x,
                  peer_y, peer_kind, final_pair, entry_gain, entry_reach, input ready);
  modport sink (input valid, op, self_x, self_y, self_vx, self_vy, self_kind, peer_x,
                peer_y, peer_kind, final_pair, entry_gain, entry_reach, output ready);
endinterface

interface ppfi_res_if;
  import ppfi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [31:0]             next_x;
  logic [31:0]             next_y;
  logic signed [POS_W-1:0] next_vx;
  logic signed [POS_W-1:0] next_vy;
  logic [9:0]              cell_index;
  modport source (output valid, next_x, next_y, next_vx, next_vy, cell_index, input ready);
  modport sink (input valid, next_x, next_y, next_vx, next_vy, cell_index, output ready);
endinterface

interface ppfi_cfg_if;
  import ppfi_pkg::*;
  logic             valid;
  logic             ready;
  cfg_reg_t         index;
  logic [CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/particle_pair_force_integrator_core.sv
// Pairwise force integrator for particle-life style motion. One pair item at a time: a
// near pair (separation under 2^34 on both axes) runs the force path, a far pair skips
// it, a table load writes one entry, and the final pair of a run adds friction and the
// position step. The work is done by two 64-step shift-add multipliers (x and y lanes,
// four rounds on a near pair and two more on the final one), a 36-step square root and
// a 56-step restoring divider. The force table (TYPES*TYPES entries) lives in a RAM and
// must be loaded before a type pair is used. Results sit in an output register, so the
// next item is taken while a result waits. Depends on ppfi_pkg, ppfi_ifs, ppfi_ram and
// ppfi_mul.
module particle_pair_force_integrator_core (
  input logic        clk,
  input logic        rst,
  ppfi_pair_if.sink  pair_in,
  ppfi_res_if.source res_out,
  ppfi_cfg_if.sink   cfg
);
  import ppfi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_SQRT, S_BAND1, S_BAND2, S_MAG, S_DIV, S_IMP1, S_IMP2, S_ACC,
    S_CHK, S_FRIC, S_STEP, S_WRAP1, S_WRAP2, S_CELL, S_IDX, S_DONE
  } state_t;

  state_t state;
  state_t prev_state;

  // configuration
  logic [23:0] repel_gain;
  logic [31:0] near_radius;
  logic [31:0] quiet_band;
  logic [15:0] damping;
  logic [23:0] time_step;
  logic [10:0] cell_size;
  logic [5:0]  cells_across;
  logic [5:0]  cells_down;

  // run and item state
  logic                    run_open;
  logic signed [39:0]      vel_x, vel_y;
  logic signed [39:0]      sx, sy;
  logic                    fin, kok;
  logic                    negx, negy;
  logic [33:0]             adx, ady;
  logic [71:0]             rad;
  logic [39:0]             sq_rem;
  logic [35:0]             root;
  logic [5:0]              cnt;
  logic                    far, close;
  logic [35:0]             xp;
  logic [31:0]             rdiff;
  logic                    magneg;
  logic [55:0]             dv_q;
  logic [35:0]             dv_rem;
  logic signed [39:0]      vx, vy;
  logic signed [48:0]      px, py;
  logic [31:0]             nx, ny;
  logic [15:0]             cx_q, cy_q;
  logic [10:0]             cx_rem, cy_rem;
  logic [9:0]              region;

  // multiplier lanes
  logic         mul_go;
  logic [63:0]  mx_a, mx_b, my_a, my_b;
  logic         mx_done, my_done;
  logic [127:0] mx_prod, my_prod;

  ppfi_mul u_mul_x (.clk, .rst, .start(mul_go), .a(mx_a), .b(mx_b),
                    .done(mx_done), .prod(mx_prod));
  ppfi_mul u_mul_y (.clk, .rst, .start(mul_go), .a(my_a), .b(my_b),
                    .done(my_done), .prod(my_prod));

  // a multiply round starts on the first cycle of each multiply state
  assign mul_go = (state != prev_state) &&
                  (state == S_SQ || state == S_MAG || state == S_IMP1 ||
                   state == S_IMP2 || state == S_FRIC || state == S_STEP);

  // input side
  logic              acc;
  logic              in_ok;
  logic [TBL_AW-1:0] tbl_idx;
  logic signed [40:0] dx_in, dy_in;
  logic [40:0]       ax_in, ay_in;
  logic              near_in;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;

  assign pair_in.ready = (state == S_IDLE);
  assign acc     = pair_in.valid & pair_in.ready;
  assign in_ok   = (int'(pair_in.self_kind) < TYPES) && (int'(pair_in.peer_kind) < TYPES);
  assign tbl_idx = TBL_AW'(int'(pair_in.self_kind) * TYPES + int'(pair_in.peer_kind));
  assign dx_in   = 41'(pair_in.self_x) - 41'(pair_in.peer_x);
  assign dy_in   = 41'(pair_in.self_y) - 41'(pair_in.peer_y);
  assign ax_in   = dx_in[40] ? 41'(-dx_in) : 41'(dx_in);
  assign ay_in   = dy_in[40] ? 41'(-dy_in) : 41'(dy_in);
  assign near_in = (ax_in[40:34] == '0) && (ay_in[40:34] == '0);

  ppfi_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_DEPTH)) u_table (
    .clk,
    .we    (acc & pair_in.op & in_ok),
    .waddr (tbl_idx),
    .wdata ({pair_in.entry_gain, pair_in.entry_reach}),
    .re    (acc & ~pair_in.op),
    .raddr (tbl_idx),
    .rdata (ram_rdata)
  );
  assign rd_entry = entry_t'(ram_rdata);

  assign cfg.ready = 1'b1;

  // clamped world geometry
  logic [10:0] cs_c;
  logic [5:0]  ca_c, cd_c;
  logic [31:0] world_x, world_y;
  assign cs_c = (cell_size == '0) ? 11'd1 : ((cell_size > 11'd1024) ? 11'd1024 : cell_size);
  assign ca_c = (cells_across == '0) ? 6'd1 : ((cells_across > 6'd32) ? 6'd32 : cells_across);
  assign cd_c = (cells_down == '0) ? 6'd1 : ((cells_down > 6'd32) ? 6'd32 : cells_down);
  assign world_x = {16'(17'(cs_c) * 17'(ca_c)), 16'd0};
  assign world_y = {16'(17'(cs_c) * 17'(cd_c)), 16'd0};

  // square root step
  logic [39:0] rem_sh, sq_trial;
  logic        sq_ge;
  assign rem_sh   = {sq_rem[37:0], rad[71:70]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge    = rem_sh >= sq_trial;

  // divider step
  logic [36:0] dv_sh;
  logic        dv_ge;
  assign dv_sh = {dv_rem, dv_q[55]};
  assign dv_ge = dv_sh >= {1'b0, root};

  // cell divider steps
  logic [11:0] cxs, cys;
  logic        cx_ge, cy_ge;
  assign cxs   = {cx_rem, cx_q[15]};
  assign cys   = {cy_rem, cy_q[15]};
  assign cx_ge = cxs >= {1'b0, cs_c};
  assign cy_ge = cys >= {1'b0, cs_c};

  // band selection
  logic [32:0] rq;
  logic        xp_lt;
  logic [31:0] reach_m_xp, t_tri;
  logic [24:0] gain_abs;
  assign rq         = 33'(near_radius) + 33'(quiet_band);
  assign xp_lt      = xp < 36'(rd_entry.reach);
  assign reach_m_xp = rd_entry.reach - xp[31:0];
  assign t_tri      = (xp[31:0] < reach_m_xp) ? xp[31:0] : reach_m_xp;
  assign gain_abs   = rd_entry.gain[24] ? 25'(-rd_entry.gain) : 25'(rd_entry.gain);

  // impulse and saturating add
  logic [79:0]        wide_x, wide_y;
  logic [40:0]        r_x, r_y;
  logic signed [41:0] imp_x, imp_y;
  logic signed [42:0] sum_x, sum_y;
  logic signed [39:0] sat_x, sat_y;
  assign wide_x = mx_prod[127:48];
  assign wide_y = my_prod[127:48];
  assign r_x = (wide_x > 80'h100_0000_0000) ? 41'h100_0000_0000 : wide_x[40:0];
  assign r_y = (wide_y > 80'h100_0000_0000) ? 41'h100_0000_0000 : wide_y[40:0];
  assign imp_x = (negx ^ magneg) ? -$signed({1'b0, r_x}) : $signed({1'b0, r_x});
  assign imp_y = (negy ^ magneg) ? -$signed({1'b0, r_y}) : $signed({1'b0, r_y});
  assign sum_x = 43'(vel_x) + 43'(imp_x);
  assign sum_y = 43'(vel_y) + 43'(imp_y);
  assign sat_x = (sum_x > 43'(VMAX)) ? VMAX : ((sum_x < 43'(VMIN)) ? VMIN : sum_x[39:0]);
  assign sat_y = (sum_y > 43'(VMAX)) ? VMAX : ((sum_y < 43'(VMIN)) ? VMIN : sum_y[39:0]);

  // friction and position step
  logic [16:0] keep;
  logic [39:0] vabs_x, vabs_y;
  logic [39:0] fm_x, fm_y;
  logic [46:0] st_x, st_y;
  assign keep   = 17'h10000 - 17'(damping);
  assign vabs_x = vel_x[39] ? 40'(-vel_x) : 40'(vel_x);
  assign vabs_y = vel_y[39] ? 40'(-vel_y) : 40'(vel_y);
  assign fm_x   = mx_prod[55:16];
  assign fm_y   = my_prod[55:16];
  assign st_x   = mx_prod[62:16];
  assign st_y   = my_prod[62:16];

  // wrap
  logic signed [48:0] wx_s, wy_s;
  logic [31:0]        nx_c, ny_c;
  assign wx_s = $signed({17'd0, world_x});
  assign wy_s = $signed({17'd0, world_y});
  assign nx_c = px[48] ? 32'd0 : ((px >= wx_s) ? world_x - 32'd1 : px[31:0]);
  assign ny_c = py[48] ? 32'd0 : ((py >= wy_s) ? world_y - 32'd1 : py[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prev_state    <= S_IDLE;
      run_open      <= 1'b0;
      vel_x         <= '0;
      vel_y         <= '0;
      res_out.valid <= 1'b0;
      repel_gain    <= 24'd65536;
      near_radius   <= 32'd1310720;
      quiet_band    <= 32'd327680;
      damping       <= 16'd3277;
      time_step     <= 24'd65536;
      cell_size     <= 11'd100;
      cells_across  <= 6'd8;
      cells_down    <= 6'd8;
    end else begin
      prev_state <= state;
      if (res_out.ready && state != S_DONE) begin
        res_out.valid <= 1'b0;
      end

      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_REPEL_GAIN:   repel_gain   <= cfg.data[23:0];
          CFG_NEAR_RADIUS:  near_radius  <= cfg.data;
          CFG_QUIET_BAND:   quiet_band   <= cfg.data;
          CFG_DAMPING:      damping      <= cfg.data[15:0];
          CFG_TIME_STEP:    time_step    <= cfg.data[23:0];
          CFG_CELL_SIZE:    cell_size    <= cfg.data[10:0];
          CFG_CELLS_ACROSS: cells_across <= cfg.data[5:0];
          CFG_CELLS_DOWN:   cells_down   <= cfg.data[5:0];
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (acc && !pair_in.op) begin
            if (!run_open) begin
              vel_x <= pair_in.self_vx;
              vel_y <= pair_in.self_vy;
            end
            run_open <= 1'b1;
            sx   <= pair_in.self_x;
            sy   <= pair_in.self_y;
            fin  <= pair_in.final_pair;
            kok  <= in_ok;
            negx <= dx_in[40];
            negy <= dy_in[40];
            adx  <= ax_in[33:0];
            ady  <= ay_in[33:0];
            if (near_in) begin
              mx_a   <= 64'(ax_in[33:0]);
              mx_b   <= 64'(ax_in[33:0]);
              my_a   <= 64'(ay_in[33:0]);
              my_b   <= 64'(ay_in[33:0]);
              state  <= S_SQ;
            end else begin
              state <= S_CHK;
            end
          end
        end
        S_SQ: begin
          if (mx_done) begin
            rad    <= 72'(69'(mx_prod[67:0]) + 69'(my_prod[67:0]));
            sq_rem <= '0;
            root   <= '0;
            cnt    <= '0;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          rad    <= {rad[69:0], 2'b00};
          sq_rem <= sq_ge ? rem_sh - sq_trial : rem_sh;
          root   <= {root[34:0], sq_ge};
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd35) begin
            state <= S_BAND1;
          end
        end
        S_BAND1: begin
          far   <= {3'b000, rq} < root;
          xp    <= root - 36'(rq);
          close <= root <= 36'(near_radius);
          rdiff <= near_radius - root[31:0];
          state <= (root == '0) ? S_CHK : S_BAND2;
        end
        S_BAND2: begin
          priority if (far && kok && xp_lt) begin
            mx_a   <= 64'(t_tri);
            mx_b   <= 64'(gain_abs);
            magneg <= rd_entry.gain[24];
          end else if (!far && close) begin
            mx_a   <= 64'(rdiff);
            mx_b   <= 64'(repel_gain);
            magneg <= 1'b0;
          end else begin
            mx_a   <= '0;
            mx_b   <= '0;
            magneg <= 1'b0;
          end
          state  <= S_MAG;
        end
        S_MAG: begin
          if (mx_done) begin
            dv_q   <= mx_prod[55:0];
            dv_rem <= '0;
            cnt    <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          dv_q   <= {dv_q[54:0], dv_ge};
          dv_rem <= dv_ge ? 36'(dv_sh - {1'b0, root}) : dv_sh[35:0];
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd55) begin
            mx_a   <= 64'(adx);
            mx_b   <= 64'(time_step);
            my_a   <= 64'(ady);
            my_b   <= 64'(time_step);
            state  <= S_IMP1;
          end
        end
        S_IMP1: begin
          if (mx_done) begin
            // |d|*dt, then times the ratio
            mx_a   <= mx_prod[63:0];
            mx_b   <= 64'(dv_q);
            my_a   <= my_prod[63:0];
            my_b   <= 64'(dv_q);
            state  <= S_IMP2;
          end
        end
        S_IMP2: begin
          if (mx_done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          vel_x <= sat_x;
          vel_y <= sat_y;
          state <= S_CHK;
        end
        S_CHK: begin
          if (fin) begin
            mx_a   <= 64'(vabs_x);
            mx_b   <= 64'(keep);
            my_a   <= 64'(vabs_y);
            my_b   <= 64'(keep);
            state  <= S_FRIC;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FRIC: begin
          if (mx_done) begin
            vx     <= vel_x[39] ? -$signed(fm_x) : $signed(fm_x);
            vy     <= vel_y[39] ? -$signed(fm_y) : $signed(fm_y);
            mx_a   <= 64'(fm_x);
            mx_b   <= 64'(time_step);
            my_a   <= 64'(fm_y);
            my_b   <= 64'(time_step);
            state  <= S_STEP;
          end
        end
        S_STEP: begin
          if (mx_done) begin
            px <= 49'(sx) + (vel_x[39] ? -$signed({2'b00, st_x}) : $signed({2'b00, st_x}));
            py <= 49'(sy) + (vel_y[39] ? -$signed({2'b00, st_y}) : $signed({2'b00, st_y}));
            state <= S_WRAP1;
          end
        end
        S_WRAP1: begin
          if (px[48]) begin
            px <= px + wx_s;
          end else if (px >= wx_s) begin
            px <= px - wx_s;
          end
          if (py[48]) begin
            py <= py + wy_s;
          end else if (py >= wy_s) begin
            py <= py - wy_s;
          end
          state <= S_WRAP2;
        end
        S_WRAP2: begin
          nx     <= nx_c;
          ny     <= ny_c;
          cx_q   <= nx_c[31:16];
          cy_q   <= ny_c[31:16];
          cx_rem <= '0;
          cy_rem <= '0;
          cnt    <= '0;
          state  <= S_CELL;
        end
        S_CELL: begin
          cx_q   <= {cx_q[14:0], cx_ge};
          cy_q   <= {cy_q[14:0], cy_ge};
          cx_rem <= cx_ge ? 11'(cxs - {1'b0, cs_c}) : cxs[10:0];
          cy_rem <= cy_ge ? 11'(cys - {1'b0, cs_c}) : cys[10:0];
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd15) begin
            state <= S_IDX;
          end
        end
        S_IDX: begin
          region <= 10'(22'(cy_q) * 22'(ca_c) + 22'(cx_q));
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!res_out.valid || res_out.ready) begin
            res_out.valid      <= 1'b1;
            res_out.next_x     <= nx;
            res_out.next_y     <= ny;
            res_out.next_vx    <= vx;
            res_out.next_vy    <= vy;
            res_out.cell_index <= region;
            vel_x    <= '0;
            vel_y    <= '0;
            run_open <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/ppfi_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ppfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/ppfi_mul.sv
// Bit-serial 64x64 unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on nothing; used by the force integrator core.
module ppfi_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0] a_r;
  logic [63:0] hi;
  logic [63:0] lo;
  logic [5:0]  cnt;
  logic        run;
  logic [64:0] sum;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, a_r} : 65'd0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r <= a;
        hi  <= '0;
        lo  <= b;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        hi  <= sum[64:1];
        lo  <= {sum[0], lo[63:1]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
